// ===== rtl/fkcg_pkg.sv =====
// Shared types, constants and fixed-point helpers for the Fresnel kernel generator.
package fkcg_pkg;

  localparam int unsigned MaxOrder = 16;
  localparam int unsigned FracBits = 30;
  localparam int unsigned StoreW   = FracBits + 2;
  localparam int unsigned AccW     = 48;
  localparam int unsigned OutW     = 40;
  localparam int unsigned IdxW     = 4;
  localparam int unsigned OrdW     = 5;
  localparam int unsigned PAddrW   = $clog2(MaxOrder + 1);
  localparam int unsigned AAddrW   = $clog2(MaxOrder);
  localparam int unsigned RecipW   = FracBits;

  // shared multiplier: signed operands, magnitudes multiplied in two halves
  localparam int unsigned MagAW    = AccW;
  localparam int unsigned MagBW    = StoreW;
  localparam int unsigned MulAW    = MagAW + 1;
  localparam int unsigned MulBW    = MagBW + 1;
  localparam int unsigned MulSplit = MagAW / 2;
  localparam int unsigned MulPW    = MulSplit + MagBW;
  localparam int unsigned MulFW    = MagAW + MagBW;
  localparam int unsigned MulRW    = MulFW - FracBits + 1;

  typedef struct packed {
    logic                     start;
    logic signed [MulAW-1:0]  a;
    logic signed [MulBW-1:0]  b;
  } mul_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [MulRW-1:0]  res;
  } mul_rsp_t;

  typedef struct packed {
    logic                     valid;
    logic signed [OutW-1:0]   coef;
    logic [IdxW-1:0]          idx;
    logic                     last;
  } out_item_t;

  function automatic logic signed [StoreW-1:0] sat_store(input logic signed [63:0] v);
    logic signed [StoreW-1:0] r;
    if ((&v[63:StoreW-1]) || !(|v[63:StoreW-1])) r = v[StoreW-1:0];
    else if (v[63]) r = {1'b1, {(StoreW-1){1'b0}}};
    else r = {1'b0, {(StoreW-1){1'b1}}};
    return r;
  endfunction

  function automatic logic signed [AccW-1:0] sat_acc(input logic signed [63:0] v);
    logic signed [AccW-1:0] r;
    if ((&v[63:AccW-1]) || !(|v[63:AccW-1])) r = v[AccW-1:0];
    else if (v[63]) r = {1'b1, {(AccW-1){1'b0}}};
    else r = {1'b0, {(AccW-1){1'b1}}};
    return r;
  endfunction

  function automatic logic signed [OutW-1:0] sat_out(input logic signed [63:0] v);
    logic signed [OutW-1:0] r;
    if ((&v[63:OutW-1]) || !(|v[63:OutW-1])) r = v[OutW-1:0];
    else if (v[63]) r = {1'b1, {(OutW-1){1'b0}}};
    else r = {1'b0, {(OutW-1){1'b1}}};
    return r;
  endfunction

  // round(2^30 / k) for k = 2..17
  function automatic logic [RecipW-1:0] recip(input logic [OrdW-1:0] k);
    logic [RecipW-1:0] r;
    case (k)
      5'd2:    r = 30'd536870912;
      5'd3:    r = 30'd357913941;
      5'd4:    r = 30'd268435456;
      5'd5:    r = 30'd214748365;
      5'd6:    r = 30'd178956971;
      5'd7:    r = 30'd153391689;
      5'd8:    r = 30'd134217728;
      5'd9:    r = 30'd119304647;
      5'd10:   r = 30'd107374182;
      5'd11:   r = 30'd97612893;
      5'd12:   r = 30'd89478485;
      5'd13:   r = 30'd82595525;
      5'd14:   r = 30'd76695845;
      5'd15:   r = 30'd71582788;
      5'd16:   r = 30'd67108864;
      5'd17:   r = 30'd63161284;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/fresnel_kernel_coefficient_generator_unit.sv =====
// Top level: configuration registers, output register and the generator core.
//
// One request on the slave stream carries an argument x and a kernel weight c,
// both signed Q2.30. For each request the block produces n results on the master
// stream, n being order_in_use clamped into 2..16: Legendre values P0..P(n-1)
// when output_select is 0, kernel coefficients K0..K(n-1) when it is 1. Each
// result carries the Q10.30 value, its index in the run and tlast on the final one.
// Configuration is a plain write port: cfg_we_i with cfg_idx_i 0 sets the
// order, 1 sets the output selection; write only while the block is idle.
// Every full-width product runs through one shared multiply unit, fed from
// synchronous memories; the small weights 2k-1 and k-1 are applied in the
// sequencer itself. One request is handled at a time. With Legendre output
// P0 passes the sequencer state register and the output register once the
// request is taken; kernel coefficients wait for all P and alternate values.
// Reset returns the order to 16 and the selection to kernel coefficients.
// A stall on the master side holds the result in the output register; the
// core waits with its next result until that is taken; no result is dropped.
module fresnel_kernel_coefficient_generator_unit
  import fkcg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // x_value [31:0], kernel_coeff [63:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // coefficient [39:0], index [43:40], zero [47:44]
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [4:0]  cfg_data_i
);

  localparam logic CfgOrder  = 1'b0;
  localparam logic CfgSelect = 1'b1;

  logic [OrdW-1:0]        order_q;
  logic                   select_q;
  logic [OrdW-1:0]        n_eff;
  mul_req_t               mul_req;
  mul_rsp_t               mul_rsp;
  out_item_t              emit;
  logic                   emit_ready;
  logic                   ovalid_q;
  logic signed [OutW-1:0] ocoef_q;
  logic [IdxW-1:0]        oidx_q;
  logic                   olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q  <= OrdW'(MaxOrder);
      select_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgOrder:  order_q  <= cfg_data_i;
        CfgSelect: select_q <= cfg_data_i[0];
        default:   order_q  <= order_q;
      endcase
    end
  end

  assign n_eff = (order_q < OrdW'(2)) ? OrdW'(2)
               : (order_q > OrdW'(MaxOrder)) ? OrdW'(MaxOrder) : order_q;

  fkcg_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  fkcg_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .x_i          (s_axis_tdata[31:0]),
    .c_i          (s_axis_tdata[63:32]),
    .n_i          (n_eff),
    .sel_i        (select_q),
    .mul_req_o    (mul_req),
    .mul_rsp_i    (mul_rsp),
    .emit_o       (emit),
    .emit_ready_i (emit_ready)
  );

  // load when empty or being drained
  assign emit_ready = !ovalid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (emit_ready) begin
      ovalid_q <= emit.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_ready && emit.valid) begin
      ocoef_q <= emit.coef;
      oidx_q  <= emit.idx;
      olast_q <= emit.last;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {4'b0, oidx_q, ocoef_q};
  assign m_axis_tlast  = olast_q;

endmodule

// ===== rtl/fkcg_mul.sv =====
// Shared multi-cycle fixed-point multiplier with round-half-away rescaling.
module fkcg_mul
  import fkcg_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LO   = 2'd1;
  localparam logic [1:0] PH_HI   = 2'd2;
  localparam logic [1:0] PH_SUM  = 2'd3;

  logic [1:0]              ph_q;
  logic                    done_q;
  logic [MagAW-1:0]        am_q;
  logic [MagBW-1:0]        bm_q;
  logic                    neg_q;
  logic [MulPW-1:0]        lo_q, hi_q;
  logic signed [MulRW-1:0] res_q;

  logic [MulAW-1:0]        a_abs;
  logic [MulBW-1:0]        b_abs;
  logic [MulSplit-1:0]     mult_in;
  logic [MulPW-1:0]        prod;
  logic [MulFW-1:0]        full;
  logic [MulRW-2:0]        mag;

  assign a_abs   = req_i.a[MulAW-1] ? MulAW'(-req_i.a) : MulAW'(req_i.a);
  assign b_abs   = req_i.b[MulBW-1] ? MulBW'(-req_i.b) : MulBW'(req_i.b);
  assign mult_in = (ph_q == PH_LO) ? am_q[MulSplit-1:0] : am_q[MagAW-1:MulSplit];
  assign prod    = MulPW'(mult_in) * MulPW'(bm_q);
  assign full    = {hi_q, {MulSplit{1'b0}}} + MulFW'(lo_q)
                 + (MulFW'(1) << (FracBits - 1));
  assign mag     = full[MulFW-1:FracBits];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (ph_q)
        PH_IDLE: if (req_i.start) ph_q <= PH_LO;
        PH_LO:   ph_q <= PH_HI;
        PH_HI:   ph_q <= PH_SUM;
        PH_SUM: begin
          ph_q   <= PH_IDLE;
          done_q <= 1'b1;
        end
        default: ph_q <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && (ph_q == PH_IDLE)) begin
      am_q  <= a_abs[MagAW-1:0];
      bm_q  <= b_abs[MagBW-1:0];
      neg_q <= req_i.a[MulAW-1] ^ req_i.b[MulBW-1];
    end
    if (ph_q == PH_LO) lo_q <= prod;
    if (ph_q == PH_HI) hi_q <= prod;
    if (ph_q == PH_SUM) res_q <= neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

// ===== rtl/fkcg_seq.sv =====
// Sequencer with the Legendre and alternate-value memories and the convolution accumulator.
module fkcg_seq
  import fkcg_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [StoreW-1:0] x_i,
  input  logic signed [StoreW-1:0] c_i,
  input  logic [OrdW-1:0]          n_i,
  input  logic                     sel_i,
  output mul_req_t                 mul_req_o,
  input  mul_rsp_t                 mul_rsp_i,
  output out_item_t                emit_o,
  input  logic                     emit_ready_i
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_P1    = 5'd1;
  localparam logic [4:0] ST_PREQ  = 5'd2;
  localparam logic [4:0] ST_PRD   = 5'd3;
  localparam logic [4:0] ST_PMUL1 = 5'd4;
  localparam logic [4:0] ST_PNUM  = 5'd5;
  localparam logic [4:0] ST_PMUL2 = 5'd6;
  localparam logic [4:0] ST_AREQ  = 5'd7;
  localparam logic [4:0] ST_ARD   = 5'd8;
  localparam logic [4:0] ST_AMUL1 = 5'd9;
  localparam logic [4:0] ST_ADIF  = 5'd10;
  localparam logic [4:0] ST_AMUL2 = 5'd11;
  localparam logic [4:0] ST_CI    = 5'd12;
  localparam logic [4:0] ST_CREQ  = 5'd13;
  localparam logic [4:0] ST_CRD   = 5'd14;
  localparam logic [4:0] ST_CMUL  = 5'd15;
  localparam logic [4:0] ST_KRD   = 5'd16;
  localparam logic [4:0] ST_KMUL  = 5'd17;
  localparam logic [4:0] ST_CNEXT = 5'd18;
  localparam logic [4:0] ST_EMIT  = 5'd19;

  localparam logic signed [StoreW-1:0] One = StoreW'(1) << FracBits;

  logic [4:0]               state_q, state_d, ret_q, ret_d;
  logic [OrdW-1:0]          n_q, n_d, h_q, h_d, k_q, k_d, j_q, j_d;
  logic                     sel_q, sel_d;
  logic signed [StoreW-1:0] x_q, x_d, c_q, c_d, tmp_q, tmp_d, pkm_q, pkm_d;
  logic signed [StoreW:0]   d_q, d_d;
  logic signed [AccW-1:0]   acc_q, acc_d;
  logic signed [OutW-1:0]   ocoef_q, ocoef_d;
  logic [IdxW-1:0]          oidx_q, oidx_d;
  logic                     olast_q, olast_d;

  logic signed [StoreW-1:0] pmem [MaxOrder+1];
  logic signed [StoreW-1:0] amem [MaxOrder];
  logic                     pwe, awe;
  logic [PAddrW-1:0]        pwaddr, pra, prb;
  logic [AAddrW-1:0]        awaddr, ara;
  logic signed [StoreW-1:0] pwdata, awdata, prda_q, prdb_q, ardata_q;

  logic signed [63:0]       res64;
  logic signed [StoreW-1:0] res_st;
  logic signed [MulAW-1:0]  num;
  logic signed [StoreW+OrdW:0] tm1, tm2;
  logic [OrdW:0]            m1;
  logic [OrdW-1:0]          m2, kdec, jhi;
  logic signed [OutW-1:0]   kv;

  assign res64  = {{(64-MulRW){mul_rsp_i.res[MulRW-1]}}, mul_rsp_i.res};
  assign res_st = sat_store(res64);
  assign m1     = {k_q, 1'b0} - (OrdW+1)'(1);
  assign m2     = k_q - OrdW'(1);
  assign kdec   = k_q - OrdW'(1);
  // small recurrence weights: narrow products by 2k-1 and k-1
  assign tm1    = tmp_q * $signed({1'b0, m1});
  assign tm2    = pkm_q * $signed({2'b0, m2});
  assign num    = MulAW'(tm1) - MulAW'(tm2);
  assign jhi    = (k_q <= h_q) ? (k_q - OrdW'(1)) : (h_q - OrdW'(1));
  assign kv     = sat_out({{(64-StoreW){tmp_q[StoreW-1]}}, tmp_q} - res64);

  assign in_ready_o   = (state_q == ST_IDLE);
  assign emit_o.valid = (state_q == ST_EMIT);
  assign emit_o.coef  = ocoef_q;
  assign emit_o.idx   = oidx_q;
  assign emit_o.last  = olast_q;

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    n_d     = n_q;
    h_d     = h_q;
    k_d     = k_q;
    j_d     = j_q;
    sel_d   = sel_q;
    x_d     = x_q;
    c_d     = c_q;
    tmp_d   = tmp_q;
    pkm_d   = pkm_q;
    d_d     = d_q;
    acc_d   = acc_q;
    ocoef_d = ocoef_q;
    oidx_d  = oidx_q;
    olast_d = olast_q;
    pwe     = 1'b0;
    pwaddr  = '0;
    pwdata  = '0;
    pra     = '0;
    prb     = '0;
    awe     = 1'b0;
    awaddr  = '0;
    awdata  = '0;
    ara     = '0;
    mul_req_o.start = 1'b0;
    mul_req_o.a     = '0;
    mul_req_o.b     = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          x_d    = x_i;
          c_d    = c_i;
          n_d    = n_i;
          h_d    = (n_i + OrdW'(1)) >> 1;
          sel_d  = sel_i;
          pwe    = 1'b1;
          pwaddr = '0;
          pwdata = One;
          if (!sel_i) begin
            ocoef_d = OutW'(One);
            oidx_d  = '0;
            olast_d = 1'b0;
            ret_d   = ST_P1;
            state_d = ST_EMIT;
          end else begin
            state_d = ST_P1;
          end
        end
      end
      ST_P1: begin
        pwe    = 1'b1;
        pwaddr = PAddrW'(1);
        pwdata = x_q;
        k_d    = OrdW'(2);
        if (!sel_q) begin
          ocoef_d = {{(OutW-StoreW){x_q[StoreW-1]}}, x_q};
          oidx_d  = IdxW'(1);
          olast_d = (n_q == OrdW'(2));
          ret_d   = ST_PREQ;
          state_d = ST_EMIT;
        end else begin
          state_d = ST_PREQ;
        end
      end
      ST_PREQ: begin
        if (k_q > n_q) begin
          k_d     = '0;
          state_d = ST_AREQ;
        end else begin
          pra     = PAddrW'(k_q - OrdW'(1));
          prb     = PAddrW'(k_q - OrdW'(2));
          state_d = ST_PRD;
        end
      end
      ST_PRD: begin
        pkm_d = prdb_q;
        mul_req_o.start = 1'b1;
        mul_req_o.a     = MulAW'(prda_q);
        mul_req_o.b     = MulBW'(x_q);
        state_d = ST_PMUL1;
      end
      ST_PMUL1: begin
        if (mul_rsp_i.done) begin
          tmp_d   = res_st;
          state_d = ST_PNUM;
        end
      end
      ST_PNUM: begin
        mul_req_o.start = 1'b1;
        mul_req_o.a     = num;
        mul_req_o.b     = $signed({{(MulBW-RecipW){1'b0}}, recip(k_q)});
        state_d = ST_PMUL2;
      end
      ST_PMUL2: begin
        if (mul_rsp_i.done) begin
          pwe    = 1'b1;
          pwaddr = PAddrW'(k_q);
          pwdata = res_st;
          k_d    = k_q + OrdW'(1);
          if (!sel_q && (k_q < n_q)) begin
            ocoef_d = {{(OutW-StoreW){res_st[StoreW-1]}}, res_st};
            oidx_d  = k_q[IdxW-1:0];
            olast_d = (k_q == n_q - OrdW'(1));
            ret_d   = ST_PREQ;
            state_d = ST_EMIT;
          end else begin
            state_d = ST_PREQ;
          end
        end
      end
      ST_AREQ: begin
        if (k_q == n_q) begin
          k_d     = OrdW'(1);
          state_d = ST_CI;
        end else begin
          pra     = PAddrW'(k_q);
          prb     = PAddrW'(k_q + OrdW'(1));
          state_d = ST_ARD;
        end
      end
      ST_ARD: begin
        tmp_d = prda_q;
        mul_req_o.start = 1'b1;
        mul_req_o.a     = MulAW'(prdb_q);
        mul_req_o.b     = MulBW'(x_q);
        state_d = ST_AMUL1;
      end
      ST_AMUL1: begin
        if (mul_rsp_i.done) begin
          d_d     = (StoreW+1)'(tmp_q) - (StoreW+1)'(res_st);
          state_d = ST_ADIF;
        end
      end
      ST_ADIF: begin
        mul_req_o.start = 1'b1;
        mul_req_o.a     = MulAW'(d_q);
        mul_req_o.b     = $signed({{(MulBW-RecipW){1'b0}}, recip(k_q + OrdW'(2))});
        state_d = ST_AMUL2;
      end
      ST_AMUL2: begin
        if (mul_rsp_i.done) begin
          awe     = 1'b1;
          awaddr  = k_q[AAddrW-1:0];
          awdata  = res_st;
          k_d     = k_q + OrdW'(1);
          state_d = ST_AREQ;
        end
      end
      ST_CI: begin
        acc_d = '0;
        if (k_q == n_q) begin
          // closing coefficient takes the square of the middle value
          pra     = PAddrW'(h_q);
          prb     = PAddrW'(h_q);
          state_d = ST_CRD;
        end else begin
          j_d     = (k_q <= h_q) ? '0 : (k_q - h_q);
          state_d = ST_CREQ;
        end
      end
      ST_CREQ: begin
        pra     = PAddrW'(j_q + OrdW'(1));
        prb     = PAddrW'(k_q - j_q);
        state_d = ST_CRD;
      end
      ST_CRD: begin
        mul_req_o.start = 1'b1;
        mul_req_o.a     = MulAW'(prda_q);
        mul_req_o.b     = MulBW'(prdb_q);
        state_d = ST_CMUL;
      end
      ST_CMUL: begin
        if (mul_rsp_i.done) begin
          acc_d = sat_acc(64'(acc_q) + 64'(sat_acc(res64)));
          if ((k_q == n_q) || (j_q == jhi)) begin
            ara     = kdec[AAddrW-1:0];
            state_d = ST_KRD;
          end else begin
            j_d     = j_q + OrdW'(1);
            state_d = ST_CREQ;
          end
        end
      end
      ST_KRD: begin
        tmp_d = ardata_q;
        mul_req_o.start = 1'b1;
        mul_req_o.a     = MulAW'(acc_q);
        mul_req_o.b     = MulBW'(c_q);
        state_d = ST_KMUL;
      end
      ST_KMUL: begin
        if (mul_rsp_i.done) begin
          if (sel_q) begin
            ocoef_d = kv;
            oidx_d  = kdec[IdxW-1:0];
            olast_d = (k_q == n_q);
            ret_d   = ST_CNEXT;
            state_d = ST_EMIT;
          end else begin
            state_d = ST_CNEXT;
          end
        end
      end
      ST_CNEXT: begin
        if (k_q == n_q) begin
          state_d = ST_IDLE;
        end else begin
          k_d     = k_q + OrdW'(1);
          state_d = ST_CI;
        end
      end
      ST_EMIT: begin
        if (emit_ready_i) state_d = ret_q;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
      acc_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      acc_q   <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    h_q     <= h_d;
    k_q     <= k_d;
    j_q     <= j_d;
    sel_q   <= sel_d;
    x_q     <= x_d;
    c_q     <= c_d;
    tmp_q   <= tmp_d;
    pkm_q   <= pkm_d;
    d_q     <= d_d;
    ocoef_q <= ocoef_d;
    oidx_q  <= oidx_d;
    olast_q <= olast_d;
  end

  always_ff @(posedge clk_i) begin
    if (pwe) pmem[pwaddr] <= pwdata;
    prda_q <= pmem[pra];
    prdb_q <= pmem[prb];
  end

  always_ff @(posedge clk_i) begin
    if (awe) amem[awaddr] <= awdata;
    ardata_q <= amem[ara];
  end

endmodule

// ===== sim/tb_top.sv =====
// Testbench for the Fresnel kernel coefficient generator: scoreboard with fixed-point predictor.
`timescale 1ns / 1ps

class coef_board;
  typedef struct {
    logic [39:0] coef;
    logic [3:0]  idx;
    logic        last;
  } coef_item_t;

  coef_item_t pending[$];
  int unsigned order_reg = 16;
  bit          select_reg = 1'b1;
  int unsigned mismatches = 0;

  function automatic longint clamp_bits(longint v, int unsigned bits);
    longint lim;
    lim = (longint'(1) <<< (bits - 1)) - 1;
    if (v > lim) return lim;
    if (v < -lim - 1) return -lim - 1;
    return v;
  endfunction

  // exact product scaled down by 2^30, round half away from zero, magnitude limited to 63 bits
  function automatic longint mul_round(longint a, longint b);
    logic signed [127:0] pa, pb, prod;
    logic [127:0] mag;
    bit neg;
    pa = a;
    pb = b;
    neg = (a < 0) != (b < 0);
    prod = pa * pb;
    mag = prod[127] ? -prod : prod;
    mag = (mag + (128'd1 << 29)) >> 30;
    if (mag > 128'h7fff_ffff_ffff_ffff) mag = 128'h7fff_ffff_ffff_ffff;
    return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
  endfunction

  function automatic longint recip_of(int unsigned k);
    return ((longint'(1) <<< 30) + k / 2) / k;
  endfunction

  function automatic longint mac(longint acc, longint a, longint b);
    return clamp_bits(acc + clamp_bits(mul_round(a, b), 48), 48);
  endfunction

  function automatic longint kernel_of(longint alt, longint c, longint s);
    return clamp_bits(alt - clamp_bits(mul_round(c, s), 60), 40);
  endfunction

  function void set_config(int unsigned ord, bit sel);
    order_reg = ord;
    select_reg = sel;
  endfunction

  function void note_request(logic [31:0] x_raw, logic [31:0] c_raw);
    longint p[17];
    longint alt[16];
    longint kc[16];
    longint x, c, t, num, d, acc, v;
    int unsigned n, h, i, j;
    coef_item_t e;
    x = longint'($signed(x_raw));
    c = longint'($signed(c_raw));
    n = order_reg;
    if (n < 2) n = 2;
    if (n > 16) n = 16;
    h = (n + 1) / 2;
    p[0] = clamp_bits(longint'(1) <<< 30, 32);
    p[1] = clamp_bits(x, 32);
    for (i = 2; i <= n; i++) begin
      t = clamp_bits(mul_round(x, p[i-1]), 32);
      num = longint'(2 * i - 1) * t - longint'(i - 1) * p[i-2];
      p[i] = clamp_bits(mul_round(num, recip_of(i)), 32);
    end
    for (i = 0; i < n; i++) begin
      d = p[i] - clamp_bits(mul_round(p[1], p[i+1]), 32);
      alt[i] = clamp_bits(mul_round(d, recip_of(i + 2)), 32);
    end
    for (i = 1; i <= h; i++) begin
      acc = 0;
      for (j = 0; j < i; j++) acc = mac(acc, p[j+1], p[i-j]);
      kc[i-1] = kernel_of(alt[i-1], c, acc);
    end
    for (i = h + 1; i < n; i++) begin
      acc = 0;
      for (j = i - h; j < h; j++) acc = mac(acc, p[j+1], p[i-j]);
      kc[i-1] = kernel_of(alt[i-1], c, acc);
    end
    // last coefficient uses the square of the middle value
    kc[n-1] = kernel_of(alt[n-1], c, mac(0, p[h], p[h]));
    for (i = 0; i < n; i++) begin
      v = select_reg ? kc[i] : clamp_bits(p[i], 40);
      e.coef = v[39:0];
      e.idx = i[3:0];
      e.last = (i == n - 1);
      pending.push_back(e);
    end
  endfunction

  function void check_result(logic [39:0] coef, logic [3:0] idx, logic last);
    coef_item_t e;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result coef=%h idx=%0d last=%0b", coef, idx, last);
      return;
    end
    e = pending.pop_front();
    if (coef !== e.coef || idx !== e.idx || last !== e.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected coef=%h idx=%0d last=%0b, got coef=%h idx=%0d last=%0b",
                 e.coef, e.idx, e.last, coef, idx, last);
    end
  endfunction
endclass

module tb_top;
  localparam logic CfgOrder  = 1'b0;
  localparam logic CfgSelect = 1'b1;
  localparam int unsigned CycleLimit = 4000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [4:0]  cfg_data_i = '0;

  coef_board   board = new;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit          hold_go = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;

  fresnel_kernel_coefficient_generator_unit dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off to back the block up
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready)
      board.check_result(m_axis_tdata[39:0], m_axis_tdata[43:40], m_axis_tlast);
    if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 3000;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic write_reg(logic idx, logic [4:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_request(logic [31:0] x, logic [31:0] c);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {c, x};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_request(x, c);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    // the core keeps working after its last Legendre value leaves
    while (!s_axis_tready) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_x();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 85) return 32'($urandom_range(32'h8000_0000)) - 32'h4000_0000;
    if (r < 92) return $urandom;
    return (r < 96) ? 32'h4000_0000 : 32'hc000_0000;
  endfunction

  task automatic run_phase(int unsigned ord, bit sel, int unsigned count, int unsigned mode);
    drain();
    write_reg(CfgOrder, ord[4:0]);
    write_reg(CfgSelect, {4'b0, sel});
    board.set_config(ord, sel);
    case (mode)
      0: begin
        tx_idle_pct = 8;
        rx_idle_pct = 59;
      end
      1: begin
        tx_idle_pct = 59;
        rx_idle_pct = 8;
      end
      default: begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
    endcase
    repeat (count) send_request(rand_x(), $urandom);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: argument and weight extremes at full order
    run_phase(16, 1'b1, 0, 2);
    send_request(32'h4000_0000, 32'h4000_0000);
    send_request(32'hc000_0000, 32'hc000_0000);
    send_request(32'h0000_0000, 32'h0000_0000);
    send_request(32'h7fff_ffff, 32'h7fff_ffff);
    send_request(32'h8000_0000, 32'h8000_0000);
    send_request(32'h2000_0000, 32'h8000_0000);
    send_request(32'hffff_ffff, 32'h7fff_ffff);
    send_request(32'h0000_0001, 32'hffff_ffff);
    run_phase(16, 1'b0, 0, 2);
    send_request(32'h4000_0000, 32'h0000_0000);
    send_request(32'hc000_0000, 32'h1234_5678);
    send_request(32'h7fff_ffff, 32'h8000_0000);
    send_request(32'h8000_0000, 32'h7fff_ffff);
    run_phase(0, 1'b1, 2, 2);
    run_phase(31, 1'b1, 2, 2);

    run_phase(0, 1'b0, 30, 0);
    // hold the receiver off while requests keep coming
    run_phase(31, 1'b1, 0, 0);
    hold_go = 1'b1;
    repeat (25) send_request(rand_x(), $urandom);
    run_phase(3, 1'b1, 40, 1);
    run_phase(2, 1'b0, 30, 1);
    run_phase(17, 1'b0, 20, 2);
    run_phase(1, 1'b1, 35, 2);
    for (int unsigned k = 0; k < 9; k++)
      run_phase($urandom_range(31), 1'($urandom_range(1)), 7, k % 3);

    drain();
    repeat (100) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// ===== fresnel_kernel_coefficient_generator_unit.f =====
rtl/fkcg_pkg.sv
rtl/fkcg_mul.sv
rtl/fkcg_seq.sv
rtl/fresnel_kernel_coefficient_generator_unit.sv
sim/tb_top.sv
